>>> hdl/qsu_pkg.sv
// Package for the quoted string unescaper.
// Holds the parse mode type, character codes, result struct and decode helpers.
// No dependencies.
package qsu_pkg;

    localparam logic [7:0] QUOTE_CH  = 8'h22;
    localparam logic [7:0] BSLASH_CH = 8'h5C;
    localparam logic [7:0] SQUOTE_CH = 8'h27;
    localparam logic [7:0] X_CH      = 8'h78;

    typedef enum logic [2:0] {
        MODE_OPEN = 3'd0,
        MODE_BODY = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX1 = 3'd3,
        MODE_HEX2 = 3'd4
    } t_mode;

    // One decoded result; emit marks that the input item produces a transaction.
    typedef struct packed {
        logic       emit;
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_string;
        logic       malformed;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic       known;
        logic [7:0] val;
    } t_esc;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        case (c) inside
            [8'h30:8'h39]: h.val = c[3:0];
            [8'h61:8'h66],
            [8'h41:8'h46]: h.val = c[3:0] + 4'd9;
            default:       h.ok  = 1'b0;
        endcase
        return h;
    endfunction

    function automatic t_esc escape_value(input logic [7:0] c);
        t_esc e;
        e.known = 1'b1;
        case (c)
            8'h61:     e.val = 8'd7;
            8'h62:     e.val = 8'd8;
            8'h66:     e.val = 8'd12;
            8'h6E:     e.val = 8'd10;
            8'h72:     e.val = 8'd13;
            8'h74:     e.val = 8'd9;
            8'h76:     e.val = 8'd11;
            SQUOTE_CH: e.val = SQUOTE_CH;
            QUOTE_CH:  e.val = QUOTE_CH;
            BSLASH_CH: e.val = BSLASH_CH;
            default: begin
                e.known = 1'b0;
                e.val   = 8'd0;
            end
        endcase
        return e;
    endfunction

endpackage

>>> hdl/qsu_in_if.sv
// Input channel of the quoted string unescaper: valid/ready plus one raw byte.
// No dependencies.
interface qsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

>>> hdl/qsu_out_if.sv
// Output channel of the quoted string unescaper: valid/ready plus one result.
// No dependencies.
interface qsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;
    logic       malformed;

    modport source (output valid, output out_byte, output has_byte,
                    output end_of_string, output malformed, input ready);
    modport sink   (input valid, input out_byte, input has_byte,
                    input end_of_string, input malformed, output ready);
endinterface

>>> hdl/quoted_string_unescaper.sv
// Quoted string unescaper: takes a double-quoted, C-escaped string one byte per
// transaction and delivers the decoded bytes, then one end-of-string transaction.
// A byte is registered on input, decoded by the parse state machine, and the
// result is registered on output, so the block accepts one byte every cycle
// unless a byte with a result waits on a blocked output. Both registers advance
// independently: a waiting result does not stop a byte that yields no result
// (opening quote, backslash, first hex digit, unknown escape) from being taken.
// Escapes a b f n r t v ' " \ and \xHH (either case) are decoded; an unknown
// escape letter drops both characters; an invalid hex digit counts as zero and
// marks the string. The transaction for the byte flagged final_byte carries
// end_of_string, no data, and malformed = 1 when the string must be discarded
// (bad opening or closing quote, string ending inside an escape, bad hex digit).
// Depends on qsu_pkg, qsu_in_if, qsu_out_if and qsu_decode.
module quoted_string_unescaper (
    input  logic  i_clk,
    input  logic  i_rst_n,
    qsu_in_if.sink    i_in,
    qsu_out_if.source o_out
);
    import qsu_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    t_result    w_result;
    logic       w_out_free;
    logic       w_advance;
    logic       w_in_take;

    qsu_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .i_final   (r_in_final),
        .o_result  (w_result)
    );

    // The result register is free when empty or emptied this cycle.
    assign w_out_free = !r_out_valid || o_out.ready;
    // Advance the held byte unless it has a result and the output is blocked.
    assign w_advance  = r_in_valid && (!w_result.emit || w_out_free);
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte  <= i_in.in_byte;
            r_in_final <= i_in.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_result.emit && w_out_free) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out.out_byte;
    assign o_out.has_byte      = r_out.has_byte;
    assign o_out.end_of_string = r_out.end_of_string;
    assign o_out.malformed     = r_out.malformed;

    a_full_take_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take && r_in_valid |-> w_advance)
        else $error("input register overwritten before its byte advanced");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

endmodule

>>> hdl/qsu_decode.sv
// Parse state machine of the quoted string unescaper.
// Decodes the byte held in the input register; depends on qsu_pkg.
module qsu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_byte,
    input  logic             i_final,
    output qsu_pkg::t_result o_result
);
    import qsu_pkg::*;

    t_mode      r_mode, n_mode;
    logic [3:0] r_nibble, n_nibble;
    logic       r_error, n_error;
    t_hex       w_hex;
    t_esc       w_esc;

    assign w_hex = hex_value(i_byte);
    assign w_esc = escape_value(i_byte);

    // next state
    always_comb begin
        n_mode   = r_mode;
        n_nibble = r_nibble;
        n_error  = r_error;
        if (i_final) begin
            n_mode   = MODE_OPEN;
            n_nibble = 4'd0;
            n_error  = 1'b0;
        end else begin
            case (r_mode)
                MODE_OPEN: begin
                    if (i_byte != QUOTE_CH) n_error = 1'b1;
                    n_mode = MODE_BODY;
                end
                MODE_ESC: begin
                    n_mode = (i_byte == X_CH) ? MODE_HEX1 : MODE_BODY;
                end
                MODE_HEX1: begin
                    if (!w_hex.ok) n_error = 1'b1;
                    n_nibble = w_hex.val;
                    n_mode   = MODE_HEX2;
                end
                MODE_HEX2: begin
                    if (!w_hex.ok) n_error = 1'b1;
                    n_nibble = 4'd0;
                    n_mode   = MODE_BODY;
                end
                default: begin
                    n_mode = (i_byte == BSLASH_CH) ? MODE_ESC : MODE_BODY;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_result = '0;
        if (i_final) begin
            o_result.emit          = 1'b1;
            o_result.end_of_string = 1'b1;
            o_result.malformed     = r_error || (i_byte != QUOTE_CH) ||
                                     (r_mode != MODE_BODY);
        end else begin
            case (r_mode)
                MODE_OPEN, MODE_HEX1: ;
                MODE_ESC: begin
                    if (i_byte != X_CH && w_esc.known) begin
                        o_result.emit     = 1'b1;
                        o_result.has_byte = 1'b1;
                        o_result.out_byte = w_esc.val;
                    end
                end
                MODE_HEX2: begin
                    o_result.emit     = 1'b1;
                    o_result.has_byte = 1'b1;
                    o_result.out_byte = {r_nibble, w_hex.val};
                end
                default: begin
                    if (i_byte != BSLASH_CH) begin
                        o_result.emit     = 1'b1;
                        o_result.has_byte = 1'b1;
                        o_result.out_byte = i_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OPEN;
            r_nibble <= 4'd0;
            r_error  <= 1'b0;
        end else if (i_advance) begin
            r_mode   <= n_mode;
            r_nibble <= n_nibble;
            r_error  <= n_error;
        end
    end

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_final |=> r_mode == MODE_OPEN && !r_error)
        else $error("state not cleared after end of string");

    a_hex_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !i_final && r_mode == MODE_HEX1 |=> r_mode == MODE_HEX2)
        else $error("first hex digit not followed by second");

    a_nibble_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != MODE_HEX2 |-> r_nibble == 4'd0)
        else $error("stale high nibble outside hex escape");

endmodule
